>>> rtl/pfp_pkg.sv
// Package with constants, types and state codes shared by the pressure frame parser.
`default_nettype none

package pfp_pkg;

    // Table size and frame length.
    localparam int CHANNELS    = 12;
    localparam int FRAME_BYTES = 16;

    // Widths derived from the sizes above.
    localparam int POS_W      = $clog2(FRAME_BYTES);
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

    // Field widths of the item and result ports.
    localparam int CHAN_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 16;
    localparam int ID_W       = 16;
    localparam int SID_W      = 11;
    localparam int PRESS_W    = 22;
    localparam int DIVISOR_W  = RAW_W + 1;
    localparam int DIV_CNT_W  = $clog2(PRESS_W + 1);

    // Frame layout: byte positions of the fields, header counted as byte 0.
    localparam int POS_ID_HI  = 6;
    localparam int POS_ID_LO  = 7;
    localparam int POS_CHAN   = 8;
    localparam int POS_RAW_HI = 9;
    localparam int POS_RAW_LO = 10;

    // Protocol and conversion constants.
    localparam logic [BYTE_W-1:0]  HEADER_BYTE     = 8'hAA;
    localparam logic [ID_W:0]      ID_BASE         = 17'd2047;
    localparam logic [PRESS_W-1:0] SCALE_NUM       = 22'd4000000;
    localparam logic [PRESS_W-1:0] PRESSURE_OFFSET = 22'd1000;

    // Item opcodes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result kinds.
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Configuration register indexes.
    localparam logic REG_SENSOR_ID = 1'b0;

    // Command from the parser to the executing back end.
    typedef struct packed {
        logic              kind;
        logic [CHAN_W-1:0] channel;
        logic [RAW_W-1:0]  raw;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic               kind;
        logic [CHAN_W-1:0]  channel;
        logic [PRESS_W-1:0] pressure;
    } t_result;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } t_back_state;

endpackage

`default_nettype wire

>>> rtl/pfp_front.sv
// Front end: accepts items, tracks frame bytes and issues update and read commands.
`default_nettype none

module pfp_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic                        i_opcode,
    input  wire logic [pfp_pkg::BYTE_W-1:0]  i_rx_byte,
    input  wire logic [pfp_pkg::CHAN_W-1:0]  i_read_channel,
    input  wire logic [pfp_pkg::SID_W-1:0]   i_sensor_id,
    output      logic                        o_cmd_valid,
    output      pfp_pkg::t_cmd               o_cmd
);

    logic                       r_in_frame;
    logic [pfp_pkg::POS_W-1:0]  r_pos;
    logic [pfp_pkg::ID_W-1:0]   r_id_hold;
    logic [pfp_pkg::BYTE_W-1:0] r_chan_hold;
    logic [pfp_pkg::RAW_W-1:0]  r_raw_hold;

    logic [pfp_pkg::ID_W-1:0]   n_id_hold;
    logic [pfp_pkg::BYTE_W-1:0] n_chan_hold;
    logic [pfp_pkg::RAW_W-1:0]  n_raw_hold;

    logic                       byte_in;
    logic                       last_byte;
    logic [pfp_pkg::ID_W:0]     id_sum;
    logic                       frame_ok;

    assign byte_in   = i_valid && (i_opcode == pfp_pkg::OP_BYTE);
    assign last_byte = (r_pos == pfp_pkg::POS_W'(pfp_pkg::FRAME_BYTES - 1));

    // Field capture; the check on the last byte sees the byte just arriving.
    always_comb begin
        n_id_hold   = r_id_hold;
        n_chan_hold = r_chan_hold;
        n_raw_hold  = r_raw_hold;
        if (r_in_frame) begin
            if (r_pos == pfp_pkg::POS_W'(pfp_pkg::POS_ID_HI)) begin
                n_id_hold[15:8] = i_rx_byte;
            end
            if (r_pos == pfp_pkg::POS_W'(pfp_pkg::POS_ID_LO)) begin
                n_id_hold[7:0] = i_rx_byte;
            end
            if (r_pos == pfp_pkg::POS_W'(pfp_pkg::POS_CHAN)) begin
                n_chan_hold = i_rx_byte;
            end
            if (r_pos == pfp_pkg::POS_W'(pfp_pkg::POS_RAW_HI)) begin
                n_raw_hold[15:8] = i_rx_byte;
            end
            if (r_pos == pfp_pkg::POS_W'(pfp_pkg::POS_RAW_LO)) begin
                n_raw_hold[7:0] = i_rx_byte;
            end
        end
    end

    assign id_sum   = {1'b0, n_id_hold}
                    + {{(pfp_pkg::ID_W + 1 - pfp_pkg::SID_W){1'b0}}, i_sensor_id};
    assign frame_ok = (id_sum == pfp_pkg::ID_BASE)
                   && (32'(n_chan_hold) < pfp_pkg::CHANNELS);

    always_comb begin
        o_cmd_valid = 1'b0;
        o_cmd.kind    = pfp_pkg::KIND_READ;
        o_cmd.channel = i_read_channel;
        o_cmd.raw     = n_raw_hold;
        if (i_valid && (i_opcode == pfp_pkg::OP_READ)) begin
            o_cmd_valid = 1'b1;
        end else if (byte_in && r_in_frame && last_byte && frame_ok) begin
            o_cmd_valid   = 1'b1;
            o_cmd.kind    = pfp_pkg::KIND_UPDATE;
            o_cmd.channel = n_chan_hold[pfp_pkg::CHAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
        end else if (byte_in) begin
            r_id_hold   <= n_id_hold;
            r_chan_hold <= n_chan_hold;
            r_raw_hold  <= n_raw_hold;
            if (!r_in_frame) begin
                if (i_rx_byte == pfp_pkg::HEADER_BYTE) begin
                    r_in_frame <= 1'b1;
                    r_pos      <= pfp_pkg::POS_W'(1);
                end
            end else if (last_byte) begin
                r_in_frame <= 1'b0;
                r_pos      <= '0;
            end else begin
                r_pos <= r_pos + pfp_pkg::POS_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/pfp_cmd_fifo.sv
// Short command queue between the front end and the back end.
`default_nettype none

module pfp_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pfp_pkg::t_cmd  i_data,
    input  wire logic           i_pop,
    output      pfp_pkg::t_cmd  o_data,
    output      logic           o_full,
    output      logic           o_empty
);

    pfp_pkg::t_cmd                 r_mem [pfp_pkg::CMD_DEPTH];
    logic [pfp_pkg::CMD_PTR_W-1:0] r_wr_ptr;
    logic [pfp_pkg::CMD_PTR_W-1:0] r_rd_ptr;
    logic [pfp_pkg::CMD_CNT_W-1:0] r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == pfp_pkg::CMD_CNT_W'(pfp_pkg::CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + pfp_pkg::CMD_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + pfp_pkg::CMD_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + pfp_pkg::CMD_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - pfp_pkg::CMD_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/pfp_divider.sv
// Restoring divider: the scale constant divided by a 17-bit divisor, one bit per cycle.
`default_nettype none

module pfp_divider (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [pfp_pkg::DIVISOR_W-1:0]  i_divisor,
    output      logic                           o_done,
    output      logic [pfp_pkg::PRESS_W-1:0]    o_quotient
);

    logic                            r_busy;
    logic                            r_done;
    logic [pfp_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [pfp_pkg::DIVISOR_W-1:0]   r_div;
    logic [pfp_pkg::DIVISOR_W-1:0]   r_rem;
    logic [pfp_pkg::PRESS_W-1:0]     r_quo;

    logic [pfp_pkg::DIVISOR_W:0]     partial;
    logic [pfp_pkg::DIVISOR_W:0]     diff;
    logic                            fits;

    // The quotient register starts out holding the dividend and shifts it
    // out from the top while the quotient bits shift in at the bottom.
    assign partial = {r_rem, r_quo[pfp_pkg::PRESS_W-1]};
    assign fits    = (partial >= {1'b0, r_div});
    assign diff    = partial - {1'b0, r_div};

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pfp_pkg::DIV_CNT_W'(pfp_pkg::PRESS_W);
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_quo  <= pfp_pkg::SCALE_NUM;
            end else if (r_busy) begin
                r_rem <= fits ? diff[pfp_pkg::DIVISOR_W-1:0]
                              : partial[pfp_pkg::DIVISOR_W-1:0];
                r_quo <= {r_quo[pfp_pkg::PRESS_W-2:0], fits};
                r_cnt <= r_cnt - pfp_pkg::DIV_CNT_W'(1);
                if (r_cnt == pfp_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/pfp_back.sv
// Back end: runs queued commands, owns the pressure table and the result register.
`default_nettype none

module pfp_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_empty,
    input  wire pfp_pkg::t_cmd  i_cmd,
    output      logic           o_cmd_pop,
    output      logic           o_res_valid,
    output      pfp_pkg::t_result o_res,
    input  wire logic           i_res_pop
);

    pfp_pkg::t_back_state          r_state;
    pfp_pkg::t_back_state          n_state;
    pfp_pkg::t_cmd                 r_cmd;

    logic [pfp_pkg::PRESS_W-1:0]   r_tbl     [pfp_pkg::CHANNELS];
    logic [pfp_pkg::CHANNELS-1:0]  r_tbl_vld;

    logic                          r_res_valid;
    pfp_pkg::t_result              r_res;

    logic                          div_start;
    logic                          div_done;
    logic [pfp_pkg::PRESS_W-1:0]   quotient;
    logic [pfp_pkg::PRESS_W-1:0]   pressure;
    logic [pfp_pkg::PRESS_W-1:0]   tbl_value;
    logic [pfp_pkg::CH_IDX_W-1:0]  tbl_idx;
    logic                          chan_in_range;
    logic                          slot_free;
    logic                          res_load;
    logic                          tbl_we;

    pfp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  ({1'b0, i_cmd.raw} + pfp_pkg::DIVISOR_W'(1)),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign slot_free     = !r_res_valid || i_res_pop;
    assign chan_in_range = (32'(r_cmd.channel) < pfp_pkg::CHANNELS);
    assign tbl_idx       = pfp_pkg::CH_IDX_W'(r_cmd.channel);
    assign tbl_value     = (chan_in_range && r_tbl_vld[tbl_idx]) ? r_tbl[tbl_idx] : '0;
    assign pressure      = (quotient > pfp_pkg::PRESSURE_OFFSET)
                         ? (quotient - pfp_pkg::PRESSURE_OFFSET) : '0;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfp_pkg::BK_IDLE: begin
                if (!i_cmd_empty) begin
                    n_state = (i_cmd.kind == pfp_pkg::KIND_UPDATE) ? pfp_pkg::BK_DIV
                                                                   : pfp_pkg::BK_EMIT;
                end
            end
            pfp_pkg::BK_DIV: begin
                if (div_done) begin
                    n_state = pfp_pkg::BK_EMIT;
                end
            end
            pfp_pkg::BK_EMIT: begin
                if (slot_free) begin
                    n_state = pfp_pkg::BK_IDLE;
                end
            end
            default: n_state = pfp_pkg::BK_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_cmd_pop = 1'b0;
        div_start = 1'b0;
        res_load  = 1'b0;
        tbl_we    = 1'b0;
        case (r_state)
            pfp_pkg::BK_IDLE: begin
                o_cmd_pop = !i_cmd_empty;
                div_start = !i_cmd_empty && (i_cmd.kind == pfp_pkg::KIND_UPDATE);
            end
            pfp_pkg::BK_EMIT: begin
                res_load = slot_free;
                tbl_we   = slot_free && (r_cmd.kind == pfp_pkg::KIND_UPDATE);
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfp_pkg::BK_IDLE;
            r_res_valid <= 1'b0;
            r_tbl_vld   <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd_pop) begin
                r_cmd <= i_cmd;
            end
            if (res_load) begin
                r_res_valid    <= 1'b1;
                r_res.kind     <= r_cmd.kind;
                r_res.channel  <= r_cmd.channel;
                r_res.pressure <= (r_cmd.kind == pfp_pkg::KIND_UPDATE) ? pressure : tbl_value;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
            if (tbl_we) begin
                r_tbl_vld[tbl_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_idx] <= pressure;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

>>> rtl/pressure_frame_parser_unit.sv
// Top level of the pressure frame parser: ports, configuration register and wiring.
`default_nettype none

// Channel        Handshake                        Payload
// -------------  -------------------------------  ---------------------------------
// item in        push / full                      i_opcode, i_rx_byte, i_read_channel
// result out     empty / pop                      o_kind, o_channel, o_pressure
// configuration  psel, penable, pwrite, pready    paddr, pwdata, prdata (sensor id)
//
// A stream byte or a read is taken whenever the command queue has room;
// only reads and accepted frames enter the queue, so the stream side rarely stalls.
// A read passes from the queue to the command register and, once the result register is free,
// into the result register; a frame update runs from its last byte through the queue and
// the bit-serial divider (22 steps), then waits for a free result register before it is loaded.
// Reset is synchronous and active low; it clears the parser, queue and table.
// A full result register holds the back end, which in turn fills the queue.

module pressure_frame_parser_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Item channel.
    input  wire logic                          push,
    output      logic                          full,
    input  wire logic                          i_opcode,
    input  wire logic [pfp_pkg::BYTE_W-1:0]    i_rx_byte,
    input  wire logic [pfp_pkg::CHAN_W-1:0]    i_read_channel,
    // Result channel.
    output      logic                          empty,
    input  wire logic                          pop,
    output      logic                          o_kind,
    output      logic [pfp_pkg::CHAN_W-1:0]    o_channel,
    output      logic [pfp_pkg::PRESS_W-1:0]   o_pressure,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output      logic [31:0]                   prdata,
    output      logic                          pready
);

    logic [pfp_pkg::SID_W-1:0] r_sensor_id;

    logic             item_valid;
    logic             cmd_valid;
    pfp_pkg::t_cmd    cmd_in;
    pfp_pkg::t_cmd    cmd_head;
    logic             cmd_full;
    logic             cmd_empty;
    logic             cmd_pop;
    logic             res_valid;
    pfp_pkg::t_result res;
    logic             cfg_write;

    // The register sits at byte address zero; bit 2 of the address picks the register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == pfp_pkg::REG_SENSOR_ID)
                     ? {{(32 - pfp_pkg::SID_W){1'b0}}, r_sensor_id} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_id <= '0;
        end else if (cfg_write && (paddr[2] == pfp_pkg::REG_SENSOR_ID)) begin
            r_sensor_id <= pwdata[pfp_pkg::SID_W-1:0];
        end
    end

    // An item is transferred when push is high and the queue is not full.
    assign full       = cmd_full;
    assign item_valid = push && !cmd_full;

    pfp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (item_valid),
        .i_opcode       (i_opcode),
        .i_rx_byte      (i_rx_byte),
        .i_read_channel (i_read_channel),
        .i_sensor_id    (r_sensor_id),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd_in)
    );

    pfp_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_full  (cmd_full),
        .o_empty (cmd_empty)
    );

    pfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop)
    );

    // The result register holds the oldest result until it is transferred.
    assign empty      = !res_valid;
    assign o_kind     = res.kind;
    assign o_channel  = res.channel;
    assign o_pressure = res.pressure;

endmodule

`default_nettype wire

>>> verif/pressure_frame_parser_unit_tb.sv
// Self-checking testbench for the pressure frame parser.
`timescale 1ns / 100ps

module pressure_frame_parser_unit_tb;

    // Sizes of the run.
    localparam int LIMIT_CYCLES  = 500000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 300;

    // The sensor id register is the only one, so it sits at byte address zero.
    localparam logic [2:0] SID_ADDR = 3'(4 * int'(pfp_pkg::REG_SENSOR_ID));

    // One item as it is offered on the input side.
    typedef struct packed {
        logic                       opcode;
        logic [pfp_pkg::BYTE_W-1:0] rx_byte;
        logic [pfp_pkg::CHAN_W-1:0] read_channel;
    } t_rx_item;

    // Clock, reset and every block input start at known values.
    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         push           = 1'b0;
    logic                         i_opcode       = pfp_pkg::OP_BYTE;
    logic [pfp_pkg::BYTE_W-1:0]   i_rx_byte      = '0;
    logic [pfp_pkg::CHAN_W-1:0]   i_read_channel = '0;
    logic                         pop            = 1'b0;
    logic                         psel           = 1'b0;
    logic                         penable        = 1'b0;
    logic                         pwrite         = 1'b0;
    logic [2:0]                   paddr          = '0;
    logic [31:0]                  pwdata         = '0;

    logic                         full;
    logic                         empty;
    logic                         o_kind;
    logic [pfp_pkg::CHAN_W-1:0]   o_channel;
    logic [pfp_pkg::PRESS_W-1:0]  o_pressure;
    logic [31:0]                  prdata;
    logic                         pready;

    pressure_frame_parser_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_rx_byte      (i_rx_byte),
        .i_read_channel (i_read_channel),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_channel      (o_channel),
        .o_pressure     (o_pressure),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    // Items waiting to be offered, and readings the block still owes us, oldest first.
    t_rx_item          tx_items[$];
    pfp_pkg::t_result  awaited_readings[$];
    t_rx_item          offered_item;

    // Our own copy of the parser state and the sensor id register.
    logic                         frame_open = 1'b0;
    int                           frame_pos  = 0;
    logic [pfp_pkg::ID_W-1:0]     id_word    = '0;
    logic [pfp_pkg::BYTE_W-1:0]   chan_byte  = '0;
    logic [pfp_pkg::RAW_W-1:0]    raw_word   = '0;
    logic [pfp_pkg::PRESS_W-1:0]  press_tab[pfp_pkg::CHANNELS];
    logic [pfp_pkg::SID_W-1:0]    sid_cfg    = '0;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    logic hold_trigger    = 1'b0;
    int hold_left         = 0;
    int cycle_count       = 0;
    int error_count       = 0;
    int items_queued      = 0;
    int items_sent        = 0;
    int updates_checked   = 0;
    int reads_checked     = 0;

    initial begin
        foreach (press_tab[k]) press_tab[k] = '0;
    end

    // Predictor: advance the parser copy by one accepted item and record any reading
    // that the item must produce.
    function automatic void parse_item(input t_rx_item it);
        pfp_pkg::t_result r;
        int unsigned      quotient;
        if (it.opcode == pfp_pkg::OP_READ) begin
            r.kind     = pfp_pkg::KIND_READ;
            r.channel  = it.read_channel;
            r.pressure = (it.read_channel < pfp_pkg::CHANNELS)
                         ? press_tab[it.read_channel] : '0;
            awaited_readings.push_back(r);
        end else if (!frame_open) begin
            // Hunting: only the header byte opens a frame.
            if (it.rx_byte == pfp_pkg::HEADER_BYTE) begin
                frame_open = 1'b1;
                frame_pos  = 1;
                id_word    = '0;
                chan_byte  = '0;
                raw_word   = '0;
            end
        end else begin
            // Inside a frame every byte is data, a header byte included.
            case (frame_pos)
                pfp_pkg::POS_ID_HI:  id_word[15:8]  = it.rx_byte;
                pfp_pkg::POS_ID_LO:  id_word[7:0]   = it.rx_byte;
                pfp_pkg::POS_CHAN:   chan_byte      = it.rx_byte;
                pfp_pkg::POS_RAW_HI: raw_word[15:8] = it.rx_byte;
                pfp_pkg::POS_RAW_LO: raw_word[7:0]  = it.rx_byte;
                default: ;
            endcase
            if (frame_pos + 1 < pfp_pkg::FRAME_BYTES) begin
                frame_pos++;
            end else begin
                frame_open = 1'b0;
                frame_pos  = 0;
                if (32'(id_word) + 32'(sid_cfg) == 32'(pfp_pkg::ID_BASE)
                    && chan_byte < pfp_pkg::CHANNELS) begin
                    quotient   = 32'(pfp_pkg::SCALE_NUM) / (32'(raw_word) + 32'd1);
                    r.kind     = pfp_pkg::KIND_UPDATE;
                    r.channel  = chan_byte[pfp_pkg::CHAN_W-1:0];
                    r.pressure = (quotient > 32'(pfp_pkg::PRESSURE_OFFSET))
                                 ? pfp_pkg::PRESS_W'(quotient - 32'(pfp_pkg::PRESSURE_OFFSET))
                                 : '0;
                    press_tab[chan_byte] = r.pressure;
                    awaited_readings.push_back(r);
                end
            end
        end
    endfunction

    // Driver: a transfer happens at an edge with push high and full low. The next item
    // is loaded only once the current one has gone, so push is assigned once per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                parse_item(offered_item);
                items_sent++;
            end
            if (!push || !full) begin
                if (tx_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    offered_item   = tx_items.pop_front();
                    push           <= 1'b1;
                    i_opcode       <= offered_item.opcode;
                    i_rx_byte      <= offered_item.rx_byte;
                    i_read_channel <= offered_item.read_channel;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here and armed by a one-cycle trigger.
    always @(posedge i_clk) begin
        if (hold_trigger) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: each result transfer is compared field by field with the oldest reading owed.
    always @(posedge i_clk) begin : result_monitor
        pfp_pkg::t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (awaited_readings.size() == 0) begin
                    $error("unexpected result: kind %0d channel %0d pressure %0d",
                           o_kind, o_channel, o_pressure);
                    error_count++;
                end else begin
                    want = awaited_readings.pop_front();
                    if (o_kind !== want.kind) begin
                        $error("kind mismatch: expected %0d, got %0d", want.kind, o_kind);
                        error_count++;
                    end
                    if (o_channel !== want.channel) begin
                        $error("channel mismatch: expected %0d, got %0d",
                               want.channel, o_channel);
                        error_count++;
                    end
                    if (o_pressure !== want.pressure) begin
                        $error("pressure mismatch: expected %0d, got %0d",
                               want.pressure, o_pressure);
                        error_count++;
                    end
                    if (want.kind == pfp_pkg::KIND_READ) begin
                        reads_checked++;
                    end else begin
                        updates_checked++;
                    end
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("pressure_frame_parser_unit_tb: errors");
            $finish;
        end
    end

    task automatic queue_byte(input logic [pfp_pkg::BYTE_W-1:0] b);
        t_rx_item it;
        it.opcode       = pfp_pkg::OP_BYTE;
        it.rx_byte      = b;
        it.read_channel = pfp_pkg::CHAN_W'($urandom);
        tx_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_read(input logic [pfp_pkg::CHAN_W-1:0] ch);
        t_rx_item it;
        it.opcode       = pfp_pkg::OP_READ;
        it.rx_byte      = pfp_pkg::BYTE_W'($urandom);
        it.read_channel = ch;
        tx_items.push_back(it);
        items_queued++;
    endtask

    // A complete frame; filler bytes are random or all header bytes, and reads may be
    // slipped in between the frame bytes.
    task automatic queue_frame(input logic [pfp_pkg::ID_W-1:0] id,
                               input logic [pfp_pkg::BYTE_W-1:0] chan,
                               input logic [pfp_pkg::RAW_W-1:0] raw, input logic mix_reads,
                               input logic header_fill);
        logic [pfp_pkg::BYTE_W-1:0] b;
        for (int pos = 0; pos < pfp_pkg::FRAME_BYTES; pos++) begin
            case (pos)
                0:                   b = pfp_pkg::HEADER_BYTE;
                pfp_pkg::POS_ID_HI:  b = id[15:8];
                pfp_pkg::POS_ID_LO:  b = id[7:0];
                pfp_pkg::POS_CHAN:   b = chan;
                pfp_pkg::POS_RAW_HI: b = raw[15:8];
                pfp_pkg::POS_RAW_LO: b = raw[7:0];
                default:             b = header_fill ? pfp_pkg::HEADER_BYTE
                                                     : pfp_pkg::BYTE_W'($urandom);
            endcase
            queue_byte(b);
            if (mix_reads && $urandom_range(7) == 0) begin
                queue_read(pfp_pkg::CHAN_W'($urandom));
            end
        end
    endtask

    // Random traffic: mostly well-formed frames with random content, mixed with reads, line
    // noise and frames cut short. Noise bytes do not count toward the target.
    task automatic queue_traffic(input int target);
        int                          added;
        int                          pick;
        int                          cut;
        logic [pfp_pkg::ID_W-1:0]    good_id;
        logic [pfp_pkg::ID_W-1:0]    id;
        logic [pfp_pkg::BYTE_W-1:0]  chan;
        logic [pfp_pkg::RAW_W-1:0]   raw;
        added   = 0;
        good_id = pfp_pkg::ID_W'(32'(pfp_pkg::ID_BASE) - 32'(sid_cfg));
        while (added < target) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                id   = ($urandom_range(99) < 75) ? good_id : pfp_pkg::ID_W'($urandom);
                chan = ($urandom_range(9) != 0)
                       ? pfp_pkg::BYTE_W'($urandom_range(pfp_pkg::CHANNELS - 1))
                       : pfp_pkg::BYTE_W'($urandom_range(255, pfp_pkg::CHANNELS));
                case ($urandom_range(9))
                    0:       raw = '0;
                    1:       raw = '1;
                    2, 3, 4: raw = pfp_pkg::RAW_W'($urandom_range(4000));
                    default: raw = pfp_pkg::RAW_W'($urandom);
                endcase
                queue_frame(id, chan, raw, 1'($urandom_range(1)), 1'b0);
                added += pfp_pkg::FRAME_BYTES;
            end else if (pick < 82) begin
                queue_read(pfp_pkg::CHAN_W'($urandom));
                added++;
            end else if (pick < 92) begin
                queue_byte(pfp_pkg::BYTE_W'($urandom));
            end else begin
                cut = $urandom_range(pfp_pkg::FRAME_BYTES - 2, 1);
                queue_byte(pfp_pkg::HEADER_BYTE);
                repeat (cut) queue_byte(pfp_pkg::BYTE_W'($urandom));
                added += cut + 1;
            end
        end
    endtask

    // The sender stays quiet until every queued item has been transferred and every
    // owed reading has come back, then a little longer.
    task automatic wait_drained();
        while (items_sent != items_queued || awaited_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup and access phases of a register write, then a read-back of the same register.
    task automatic write_sensor_id(input logic [pfp_pkg::SID_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SID_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sid_cfg = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(value)) begin
            $error("prdata mismatch: expected %0d, got %0d", value, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, sender light and receiver heavy idling. With the top sensor id
        // the matching frame id is zero.
        sender_idle_pct   = 11;
        receiver_idle_pct = 68;
        write_sensor_id(pfp_pkg::SID_W'(2047));
        queue_read(pfp_pkg::CHAN_W'(0));
        queue_read(pfp_pkg::CHAN_W'(15));                        // read beyond the table
        queue_frame(16'd0, 8'd0, 16'h0000, 1'b0, 1'b0);          // largest pressure
        queue_frame(16'd0, 8'(pfp_pkg::CHANNELS - 1), 16'hFFFF, 1'b0, 1'b0); // clamps to zero
        queue_read(pfp_pkg::CHAN_W'(pfp_pkg::CHANNELS - 1));
        queue_read(pfp_pkg::CHAN_W'(0));
        queue_frame(16'hFFFF, 8'd3, 16'd100, 1'b0, 1'b0);        // id mismatch
        queue_frame(16'd0, 8'(pfp_pkg::CHANNELS), 16'd100, 1'b0, 1'b0); // just past the end
        queue_frame(16'd0, 8'hFF, 16'd100, 1'b0, 1'b0);          // largest channel byte
        queue_frame(16'd0, 8'd5, 16'd999, 1'b1, 1'b1);           // headers as data, reads inside
        queue_read(pfp_pkg::CHAN_W'(5));
        queue_read(pfp_pkg::CHAN_W'(3));
        wait_drained();

        // Random phases, each after the block has gone idle.
        write_sensor_id(pfp_pkg::SID_W'($urandom));
        queue_traffic(360);
        wait_drained();

        sender_idle_pct   = 68;
        receiver_idle_pct = 11;
        write_sensor_id(pfp_pkg::SID_W'(0));
        queue_traffic(360);
        wait_drained();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_sensor_id(pfp_pkg::SID_W'($urandom_range(2046, 1)));
        queue_traffic(330);
        wait_drained();

        // Backpressure: the receiver stops for a long stretch while reads keep coming,
        // so the command queue fills and the input side stalls.
        @(posedge i_clk);
        hold_trigger <= 1'b1;
        @(posedge i_clk);
        hold_trigger <= 1'b0;
        queue_frame(pfp_pkg::ID_W'(32'(pfp_pkg::ID_BASE) - 32'(sid_cfg)), 8'd7, 16'd42,
                    1'b0, 1'b0);
        repeat (40) queue_read(pfp_pkg::CHAN_W'($urandom));
        for (int ch = 0; ch < 16; ch++) queue_read(pfp_pkg::CHAN_W'(ch));
        wait_drained();

        $display("summary: %0d items sent, %0d table updates and %0d read answers checked",
                 items_sent, updates_checked, reads_checked);
        $display("summary: sensor ids 0, 2047 and random, three idling profiles, one long stall");
        if (error_count == 0) begin
            $display("pressure_frame_parser_unit_tb: clean");
        end else begin
            $display("pressure_frame_parser_unit_tb: errors");
        end
        $finish;
    end

endmodule
